[design/min_heap_sift_down_unit_macros.svh]
// assertion macros shared by the heap sift-down design
`ifndef MIN_HEAP_SIFT_DOWN_UNIT_MACROS_SVH
`define MIN_HEAP_SIFT_DOWN_UNIT_MACROS_SVH

// plain clocked check, off while reset is asserted
`define MHSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked implication check, consequent in the cycle after the antecedent
`define MHSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mhsd_pkg.sv]
// types and constants for the heap sift-down unit
`default_nettype none
package mhsd_pkg;

	localparam int HEAP_DEPTH = 256;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int SIZE_W     = ADDR_W + 1;
	localparam int CHILD_W    = ADDR_W + 2;
	localparam int KEY_W      = 32;
	localparam int SYM_W      = 8;
	localparam int CMD_W      = 2;
	localparam int SWAP_W     = 4;
	localparam int MAX_SWAPS  = ADDR_W;

	// input word layout, lowest bit first
	localparam int IN_IDX_LO  = 0;
	localparam int IN_SIZE_LO = IN_IDX_LO + ADDR_W;
	localparam int IN_KEY_LO  = IN_SIZE_LO + SIZE_W;
	localparam int IN_SYM_LO  = IN_KEY_LO + KEY_W;
	localparam int IN_BITS    = IN_SYM_LO + SYM_W;
	localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;

	// output word layout, lowest bit first
	localparam int OUT_KEY_LO  = 0;
	localparam int OUT_SYM_LO  = OUT_KEY_LO + KEY_W;
	localparam int OUT_FIN_LO  = OUT_SYM_LO + SYM_W;
	localparam int OUT_SWAP_LO = OUT_FIN_LO + ADDR_W;
	localparam int OUT_BITS    = OUT_SWAP_LO + SWAP_W;
	localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SIFT  = 2'd2;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic [KEY_W-1:0] key;
	} entry_t;

endpackage
`default_nettype wire

[design/mhsd_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none
module mhsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[design/min_heap_sift_down_unit.sv]
// binary min-heap store with write, read and sift-down commands
//
// channel   dir   handshake                 payload
// s_*       in    s_tvalid / s_tready       s_tuser command, s_tdata entry and indexes
// m_*       out   m_tvalid / m_tready       m_tdata read entry, final index, swap count
//
// write, unused and out-of-heap sift commands load the result register when accepted;
// a read passes S_RDATA; a sift passes S_NODE, then S_LEFT and S_RIGHT per level, then S_FIN: each level
// reads the left and right child through the single read port of the ram
// no clearing pass: the store is undefined until written, reset clears control only
// a new word is taken only when the sequencer is idle and the result register is
// free or being emptied in the same cycle
`default_nettype none
module min_heap_sift_down_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// index, heap_size, entry_frequency, entry_symbol, zero pad
	input  wire  [mhsd_pkg::IN_W-1:0]    s_tdata,
	// command
	input  wire  [mhsd_pkg::CMD_W-1:0]   s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// read_frequency, read_symbol, final_index, swap_count, zero pad
	output logic [mhsd_pkg::OUT_W-1:0]   m_tdata
);

	import mhsd_pkg::*;

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RDATA = 3'd1; // read command data arrives
	localparam logic [2:0] S_NODE  = 3'd2; // sifted entry arrives
	localparam logic [2:0] S_LEFT  = 3'd3; // left child arrives
	localparam logic [2:0] S_RIGHT = 3'd4; // right child arrives, swap decision
	localparam logic [2:0] S_FIN   = 3'd5; // sifted entry written at its rest place

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] pos_q;
	logic [SIZE_W-1:0] n_q;
	logic [SWAP_W-1:0] swaps_q;
	entry_t            node_q;
	entry_t            left_q;
	logic              left_win_q;
	logic              rc_ok_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	// input word fields
	logic [ADDR_W-1:0] in_idx;
	logic [SIZE_W-1:0] in_size;
	entry_t            in_entry;
	logic [SIZE_W-1:0] in_n;
	logic              accept;
	logic              done_now;

	assign in_idx       = s_tdata[IN_IDX_LO +: ADDR_W];
	assign in_size      = s_tdata[IN_SIZE_LO +: SIZE_W];
	assign in_entry.key = s_tdata[IN_KEY_LO +: KEY_W];
	assign in_entry.sym = s_tdata[IN_SYM_LO +: SYM_W];

	// clamp heap size to the store depth
	assign in_n = (in_size > SIZE_W'(HEAP_DEPTH)) ? SIZE_W'(HEAP_DEPTH) : in_size;

	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// accepted word whose result is ready at once: write, unused, sift outside the heap
	assign done_now = accept && (s_tuser != CMD_READ) &&
		!((s_tuser == CMD_SIFT) && (SIZE_W'(in_idx) < in_n));

	// child positions of the current node
	logic [CHILD_W-1:0] lc;
	logic [CHILD_W-1:0] rc;
	logic [CHILD_W-1:0] n_ext;
	logic               lc_ok;
	logic               rc_ok;

	assign lc    = {1'b0, pos_q, 1'b1};
	assign rc    = {1'b0, pos_q, 1'b0} + CHILD_W'(2);
	assign n_ext = CHILD_W'(n_q);
	assign lc_ok = lc < n_ext;
	assign rc_ok = rc < n_ext;

	// shared ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	entry_t            ram_rdata;

	mhsd_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (HEAP_DEPTH)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// the single key comparator sits in front of the swap decision
	logic [KEY_W-1:0]   cur_key;
	logic [KEY_W-1:0]   cmp_key;
	logic               key_lt;
	logic               right_win;
	logic               do_swap;
	logic [ADDR_W-1:0]  best_idx;
	entry_t             best_entry;
	logic [CHILD_W-1:0] next_lc;
	logic               next_lc_ok;

	assign cur_key    = left_win_q ? left_q.key : node_q.key;
	// left child is measured against the node, right child against the smaller so far
	assign cmp_key    = (state_q == S_RIGHT) ? cur_key : node_q.key;
	assign key_lt     = ram_rdata.key < cmp_key;
	assign right_win  = rc_ok_q && key_lt;
	assign do_swap    = left_win_q || right_win;
	assign best_idx   = right_win ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
	assign best_entry = right_win ? ram_rdata : left_q;
	assign next_lc    = {1'b0, best_idx, 1'b1};
	assign next_lc_ok = next_lc < n_ext;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = node_q;
		ram_re    = 1'b0;
		ram_raddr = lc[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				ram_waddr = in_idx;
				ram_wdata = in_entry;
				ram_raddr = in_idx;
				if (accept) begin
					ram_we = (s_tuser == CMD_WRITE);
					ram_re = (s_tuser == CMD_READ) ||
						((s_tuser == CMD_SIFT) && (SIZE_W'(in_idx) < in_n));
				end
			end
			S_NODE: begin
				ram_re = lc_ok;
			end
			S_LEFT: begin
				ram_re    = rc_ok;
				ram_raddr = rc[ADDR_W-1:0];
			end
			S_RIGHT: begin
				// chosen child moves up, and in the same cycle its left child is fetched if inside the heap
				ram_we    = do_swap;
				ram_wdata = best_entry;
				ram_re    = do_swap && next_lc_ok;
				ram_raddr = next_lc[ADDR_W-1:0];
			end
			S_FIN: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// result word builder
	function automatic logic [OUT_W-1:0] pack_out(
		input entry_t            e,
		input logic [ADDR_W-1:0] fin,
		input logic [SWAP_W-1:0] swaps
	);
		logic [OUT_W-1:0] w;
		w = '0;
		w[OUT_KEY_LO +: KEY_W]   = e.key;
		w[OUT_SYM_LO +: SYM_W]   = e.sym;
		w[OUT_FIN_LO +: ADDR_W]  = fin;
		w[OUT_SWAP_LO +: SWAP_W] = swaps;
		return w;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !done_now) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_tuser == CMD_READ) begin
							state_q <= S_RDATA;
						end else if ((s_tuser == CMD_SIFT) && (SIZE_W'(in_idx) < in_n)) begin
							state_q <= S_NODE;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_RDATA: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_NODE: begin
					state_q <= lc_ok ? S_LEFT : S_FIN;
				end
				S_LEFT: begin
					state_q <= S_RIGHT;
				end
				S_RIGHT: begin
					state_q <= (do_swap && next_lc_ok) ? S_LEFT : S_FIN;
				end
				S_FIN: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pos_q   <= in_idx;
				n_q     <= in_n;
				swaps_q <= '0;
				if (accept) begin
					if (s_tuser == CMD_SIFT) begin
						// start outside the heap: rest at the start index
						out_data_q <= pack_out('0, in_idx, '0);
					end else begin
						out_data_q <= '0;
					end
				end
			end
			S_RDATA: begin
				out_data_q <= pack_out(ram_rdata, '0, '0);
			end
			S_NODE: begin
				node_q <= ram_rdata;
			end
			S_LEFT: begin
				left_q     <= ram_rdata;
				left_win_q <= key_lt;
				rc_ok_q    <= rc_ok;
			end
			S_RIGHT: begin
				if (do_swap) begin
					pos_q   <= best_idx;
					swaps_q <= swaps_q + SWAP_W'(1);
				end
			end
			S_FIN: begin
				out_data_q <= pack_out('0, pos_q, swaps_q);
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	`include "min_heap_sift_down_unit_macros.svh"

	`MHSD_ASSERT(a_swap_bound, (swaps_q <= SWAP_W'(MAX_SWAPS)) || (state_q == S_IDLE), "swap count beyond tree depth")
	`MHSD_ASSERT(a_pos_in_heap, !((state_q == S_LEFT) || (state_q == S_RIGHT)) || (SIZE_W'(pos_q) < n_q), "sift position left the heap")
	`MHSD_ASSERT(a_no_rw_clash, !(ram_we && ram_re && (state_q != S_IDLE)) || (ram_waddr != ram_raddr), "ram read and write hit one entry")
	`MHSD_ASSERT_NEXT(a_fin_result, state_q == S_FIN, out_valid_q && (state_q == S_IDLE), "sift end gave no result")

endmodule
`default_nettype wire
